FILE: rtl/core/bba_pkg.sv
// bba_pkg: types, constants and helper functions of the buddy block allocator
// no dependencies; used by buddy_block_allocator
package bba_pkg;

    localparam int TopBlocks    = 32;
    localparam int MaxOrder     = 10;
    localparam int MinBlockBytes = 128;
    localparam int HeaderBytes  = 32;

    localparam int IDX_W    = 15;
    localparam int PTR_W    = IDX_W + 1;
    localparam int ORD_W    = 4;
    localparam int ENTRY_W  = 6;
    localparam int BLK_W    = 16;
    localparam int BYTE_W   = 23;
    localparam int PoolUnits = TopBlocks << MaxOrder;

    // block table entry: bit 5 start, bit 4 free, bits 3..0 order
    localparam logic [ENTRY_W-1:0] E_START = 6'h20;
    localparam logic [ENTRY_W-1:0] E_FREE  = 6'h10;

    typedef logic [ENTRY_W-1:0] entry_t;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_FREE    = 2'd1;
    localparam logic [1:0] KIND_REALLOC = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [1:0] STAT_BAD_SIZE = 2'd2;
    localparam logic [1:0] STAT_IGNORED  = 2'd3;

    localparam logic [BLK_W-1:0]  RESET_BLOCKS = BLK_W'(TopBlocks);
    localparam logic [BYTE_W-1:0] RESET_BYTES  =
        BYTE_W'(TopBlocks * ((MinBlockBytes << MaxOrder) - HeaderBytes));

    // payload bytes of a block of order k
    function automatic logic [BYTE_W-1:0] payload(input logic [ORD_W-1:0] k);
        payload = (BYTE_W'(MinBlockBytes) << k) - BYTE_W'(HeaderBytes);
    endfunction

    // order field clamped to the top order
    function automatic logic [ORD_W-1:0] order_at(input entry_t e);
        order_at = (e[ORD_W-1:0] > ORD_W'(MaxOrder)) ? ORD_W'(MaxOrder) : e[ORD_W-1:0];
    endfunction

    function automatic entry_t make_entry(input logic is_free, input logic [ORD_W-1:0] k);
        make_entry = E_START | (is_free ? E_FREE : '0) | ENTRY_W'(k);
    endfunction

    // allocated block start with a legal order
    function automatic logic is_alloc(input entry_t e);
        is_alloc = ((e & (E_START | E_FREE)) == E_START)
                && (e[ORD_W-1:0] <= ORD_W'(MaxOrder));
    endfunction

endpackage

FILE: rtl/core/bba_ram.sv
// bba_ram: generic single write port, single read port ram with registered read
// no dependencies
module bba_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/buddy_block_allocator.sv
// buddy_block_allocator: buddy allocator over a pool of 128-byte units
// depends on bba_pkg and bba_ram
//
// usage
// - request channel (req_valid / req_stall): kind, request_bytes, block_index,
//   old_present; a transfer happens when req_valid is high and req_stall low
// - response channel (rsp_valid / rsp_stall): status, granted block, moved flag
//   and the four pool counters after the request
// - one response per request, in order; one request is worked on at a time,
//   the next request is taken in the cycle after the response is loaded
// - the block table (one 6-bit entry per unit) lives in a ram with a registered
//   read; all work is read, check, write back through its two ports
// - a refused size or an unused kind goes straight to the response; free merges
//   level by level; allocate runs a first-fit scan (the scan walks the pool from
//   unit 0 in block-sized steps) for the fitting order, then for each larger
//   order, and splits the block found down to size; reallocate either keeps its
//   block, grows in place level by level, or, when growth fails, moves: it
//   allocates a new block and then frees the old one with the usual merge
// - after reset a clearing pass writes all 32768 table entries, one a cycle,
//   and req_stall stays high until the pass is done
// - a response waits in its output register while rsp_stall is high; the
//   next request may be accepted meanwhile but its result holds until the
//   output register is free
module buddy_block_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  kind,
    input  logic [26:0] request_bytes,
    input  logic [14:0] block_index,
    input  logic        old_present,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic [14:0] result_index,
    output logic [3:0]  result_order,
    output logic        moved,
    output logic [15:0] free_blocks,
    output logic [21:0] free_bytes,
    output logic [15:0] total_blocks,
    output logic [21:0] total_bytes
);

    localparam int IW = bba_pkg::IDX_W;
    localparam int PW = bba_pkg::PTR_W;
    localparam int OW = bba_pkg::ORD_W;
    localparam int BW = bba_pkg::BLK_W;
    localparam int YW = bba_pkg::BYTE_W;
    localparam logic [OW-1:0] MAX_ORD = OW'(bba_pkg::MaxOrder);

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_DECODE, ST_FREE_CHK, ST_RE_CHK,
        ST_MERGE_RD, ST_MERGE_CHK, ST_MERGE_END,
        ST_GROW_RD, ST_GROW_CHK, ST_GROW_WR,
        ST_SCAN_RD, ST_SCAN_CHK, ST_SPLIT, ST_FINISH
    } state_t;

    state_t state_reg;

    // captured request
    logic [1:0]    kind_reg;
    logic [26:0]   req_bytes_reg;
    logic [IW-1:0] idx_reg;
    logic          old_reg;

    // working registers
    logic [IW-1:0] init_ptr_reg;
    logic [OW-1:0] dest_reg;
    logic [OW-1:0] o0_reg;
    logic [IW-1:0] cur_i_reg;
    logic [OW-1:0] cur_o_reg;
    logic [OW-1:0] s_reg;
    logic [PW-1:0] p_reg;
    logic [IW-1:0] gi_reg;
    logic          move_reg;

    // result under construction
    logic [1:0]    stat_reg;
    logic [IW-1:0] rindex_reg;
    logic [OW-1:0] rorder_reg;
    logic          moved_reg;

    // pool counters
    logic [BW-1:0] free_blk_reg;
    logic [BW-1:0] total_blk_reg;
    logic [YW-1:0] free_byte_reg;
    logic [YW-1:0] total_byte_reg;

    // response register
    logic          rsp_valid_reg;
    logic [1:0]    status_reg;
    logic [IW-1:0] result_index_reg;
    logic [OW-1:0] result_order_reg;
    logic          moved_out_reg;
    logic [BW-1:0] free_blocks_reg;
    logic [21:0]   free_bytes_reg;
    logic [BW-1:0] total_blocks_reg;
    logic [21:0]   total_bytes_reg;

    // table ram
    logic                 ram_we;
    logic [IW-1:0]        ram_wa;
    bba_pkg::entry_t      ram_wd;
    logic                 ram_re;
    logic [IW-1:0]        ram_ra;
    bba_pkg::entry_t      ram_rd;

    bba_ram #(
        .WIDTH (bba_pkg::ENTRY_W),
        .DEPTH (bba_pkg::PoolUnits)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_en   (ram_re),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    // smallest order whose payload fits the request
    logic [OW-1:0] size_dest;
    logic          size_bad;

    always_comb
    begin
        size_dest = MAX_ORD;
        for (int k = bba_pkg::MaxOrder; k >= 0; k--)
        begin
            if (req_bytes_reg <= 27'(bba_pkg::payload(OW'(k))))
            begin
                size_dest = OW'(k);
            end
        end
        size_bad = (req_bytes_reg == '0)
                || (req_bytes_reg > 27'(bba_pkg::payload(MAX_ORD)));
    end

    // buddy geometry of the current block
    logic [IW-1:0] cur_bit;
    logic [IW-1:0] cur_lo;
    logic [IW-1:0] cur_hi;
    logic [OW-1:0] rd_ord;
    logic          scan_hit;
    logic [PW-1:0] p_step;
    logic [OW-1:0] s_dn;

    assign cur_bit  = IW'(1) << cur_o_reg;
    assign cur_lo   = cur_i_reg & ~cur_bit;
    assign cur_hi   = cur_i_reg | cur_bit;
    assign rd_ord   = bba_pkg::order_at(ram_rd);
    assign scan_hit = ((ram_rd & bba_pkg::E_FREE) != '0) && (rd_ord == s_reg);
    assign p_step   = p_reg + (PW'(1) << rd_ord);
    assign s_dn     = s_reg - OW'(1);

    logic out_free;
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // ram port control
    always_comb
    begin
        ram_we = 1'b0;
        ram_wa = '0;
        ram_wd = '0;
        ram_re = 1'b0;
        ram_ra = '0;
        case (state_reg)
            ST_INIT:
            begin
                ram_we = 1'b1;
                ram_wa = init_ptr_reg;
                if (init_ptr_reg[bba_pkg::MaxOrder-1:0] == '0)
                begin
                    ram_wd = bba_pkg::make_entry(1'b1, MAX_ORD);
                end
            end
            ST_DECODE:
            begin
                ram_re = 1'b1;
                ram_ra = idx_reg;
            end
            ST_MERGE_RD, ST_GROW_RD:
            begin
                ram_re = (state_reg == ST_MERGE_RD) ? (cur_o_reg < MAX_ORD)
                                                    : (cur_o_reg < dest_reg);
                ram_ra = cur_i_reg ^ cur_bit;
            end
            ST_MERGE_CHK:
            begin
                ram_we = (ram_rd == bba_pkg::make_entry(1'b1, cur_o_reg));
                ram_wa = cur_hi;
            end
            ST_MERGE_END:
            begin
                ram_we = 1'b1;
                ram_wa = cur_i_reg;
                ram_wd = bba_pkg::make_entry(1'b1, cur_o_reg);
            end
            ST_GROW_WR:
            begin
                ram_we = 1'b1;
                if (cur_o_reg < dest_reg)
                begin
                    ram_wa = cur_hi;
                end
                else
                begin
                    ram_wa = cur_i_reg;
                    ram_wd = bba_pkg::make_entry(1'b0, cur_o_reg);
                end
            end
            ST_SCAN_RD:
            begin
                ram_re = !p_reg[PW-1];
                ram_ra = p_reg[IW-1:0];
            end
            ST_SCAN_CHK:
            begin
                ram_re = !scan_hit && !p_step[PW-1];
                ram_ra = p_step[IW-1:0];
            end
            ST_SPLIT:
            begin
                ram_we = 1'b1;
                if (s_reg > dest_reg)
                begin
                    ram_wa = gi_reg + (IW'(1) << s_dn);
                    ram_wd = bba_pkg::make_entry(1'b1, s_dn);
                end
                else
                begin
                    ram_wa = gi_reg;
                    ram_wd = bba_pkg::make_entry(1'b0, dest_reg);
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            kind_reg         <= '0;
            req_bytes_reg    <= '0;
            idx_reg          <= '0;
            old_reg          <= 1'b0;
            init_ptr_reg     <= '0;
            dest_reg         <= '0;
            o0_reg           <= '0;
            cur_i_reg        <= '0;
            cur_o_reg        <= '0;
            s_reg            <= '0;
            p_reg            <= '0;
            gi_reg           <= '0;
            move_reg         <= 1'b0;
            stat_reg         <= bba_pkg::STAT_OK;
            rindex_reg       <= '0;
            rorder_reg       <= '0;
            moved_reg        <= 1'b0;
            free_blk_reg     <= bba_pkg::RESET_BLOCKS;
            total_blk_reg    <= bba_pkg::RESET_BLOCKS;
            free_byte_reg    <= bba_pkg::RESET_BYTES;
            total_byte_reg   <= bba_pkg::RESET_BYTES;
            rsp_valid_reg    <= 1'b0;
            status_reg       <= bba_pkg::STAT_OK;
            result_index_reg <= '0;
            result_order_reg <= '0;
            moved_out_reg    <= 1'b0;
            free_blocks_reg  <= '0;
            free_bytes_reg   <= '0;
            total_blocks_reg <= '0;
            total_bytes_reg  <= '0;
        end
        else
        begin
            // a finishing request reloads the output register itself
            if (rsp_valid_reg && !rsp_stall && (state_reg != ST_FINISH))
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_INIT:
                begin
                    init_ptr_reg <= init_ptr_reg + IW'(1);
                    if (init_ptr_reg == '1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        kind_reg      <= kind;
                        req_bytes_reg <= request_bytes;
                        idx_reg       <= block_index;
                        old_reg       <= old_present;
                        state_reg     <= ST_DECODE;
                    end
                end

                ST_DECODE:
                begin
                    stat_reg   <= bba_pkg::STAT_OK;
                    rindex_reg <= '0;
                    rorder_reg <= '0;
                    moved_reg  <= 1'b0;
                    dest_reg   <= size_dest;
                    move_reg   <= 1'b0;
                    s_reg      <= size_dest;
                    p_reg      <= '0;
                    case (kind_reg)
                        bba_pkg::KIND_FREE:
                        begin
                            state_reg <= ST_FREE_CHK;
                        end
                        bba_pkg::KIND_ALLOC, bba_pkg::KIND_REALLOC:
                        begin
                            if (size_bad)
                            begin
                                stat_reg  <= bba_pkg::STAT_BAD_SIZE;
                                state_reg <= ST_FINISH;
                            end
                            else if (kind_reg == bba_pkg::KIND_REALLOC && old_reg)
                            begin
                                state_reg <= ST_RE_CHK;
                            end
                            else
                            begin
                                state_reg <= ST_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            stat_reg  <= bba_pkg::STAT_IGNORED;
                            state_reg <= ST_FINISH;
                        end
                    endcase
                end

                ST_FREE_CHK:
                begin
                    if (bba_pkg::is_alloc(ram_rd))
                    begin
                        free_blk_reg  <= free_blk_reg + BW'(1);
                        free_byte_reg <= free_byte_reg + bba_pkg::payload(rd_ord);
                        cur_i_reg     <= idx_reg;
                        cur_o_reg     <= rd_ord;
                        state_reg     <= ST_MERGE_RD;
                    end
                    else
                    begin
                        stat_reg  <= bba_pkg::STAT_IGNORED;
                        state_reg <= ST_FINISH;
                    end
                end

                ST_RE_CHK:
                begin
                    o0_reg    <= rd_ord;
                    cur_i_reg <= idx_reg;
                    cur_o_reg <= rd_ord;
                    if (!bba_pkg::is_alloc(ram_rd))
                    begin
                        stat_reg  <= bba_pkg::STAT_IGNORED;
                        state_reg <= ST_FINISH;
                    end
                    else if (dest_reg <= rd_ord)
                    begin
                        rindex_reg <= idx_reg;
                        rorder_reg <= rd_ord;
                        state_reg  <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_GROW_RD;
                    end
                end

                // merge loop: buddy read, then compare
                ST_MERGE_RD:
                begin
                    state_reg <= (cur_o_reg < MAX_ORD) ? ST_MERGE_CHK : ST_MERGE_END;
                end

                ST_MERGE_CHK:
                begin
                    if (ram_rd == bba_pkg::make_entry(1'b1, cur_o_reg))
                    begin
                        cur_i_reg      <= cur_lo;
                        cur_o_reg      <= cur_o_reg + OW'(1);
                        free_blk_reg   <= free_blk_reg - BW'(1);
                        total_blk_reg  <= total_blk_reg - BW'(1);
                        free_byte_reg  <= free_byte_reg + YW'(bba_pkg::HeaderBytes);
                        total_byte_reg <= total_byte_reg + YW'(bba_pkg::HeaderBytes);
                        state_reg      <= ST_MERGE_RD;
                    end
                    else
                    begin
                        state_reg <= ST_MERGE_END;
                    end
                end

                ST_MERGE_END:
                begin
                    state_reg <= ST_FINISH;
                end

                // in-place growth check over the buddy chain
                ST_GROW_RD:
                begin
                    if (cur_o_reg < dest_reg)
                    begin
                        state_reg <= ST_GROW_CHK;
                    end
                    else
                    begin
                        cur_i_reg     <= idx_reg;
                        cur_o_reg     <= o0_reg;
                        free_byte_reg <= free_byte_reg + bba_pkg::payload(o0_reg);
                        state_reg     <= ST_GROW_WR;
                    end
                end

                ST_GROW_CHK:
                begin
                    if (ram_rd == bba_pkg::make_entry(1'b1, cur_o_reg))
                    begin
                        cur_i_reg <= cur_lo;
                        cur_o_reg <= cur_o_reg + OW'(1);
                        state_reg <= ST_GROW_RD;
                    end
                    else
                    begin
                        move_reg  <= 1'b1;
                        state_reg <= ST_SCAN_RD;
                    end
                end

                ST_GROW_WR:
                begin
                    if (cur_o_reg < dest_reg)
                    begin
                        cur_i_reg      <= cur_lo;
                        cur_o_reg      <= cur_o_reg + OW'(1);
                        free_blk_reg   <= free_blk_reg - BW'(1);
                        total_blk_reg  <= total_blk_reg - BW'(1);
                        free_byte_reg  <= free_byte_reg + YW'(bba_pkg::HeaderBytes);
                        total_byte_reg <= total_byte_reg + YW'(bba_pkg::HeaderBytes);
                    end
                    else
                    begin
                        free_byte_reg <= free_byte_reg - bba_pkg::payload(cur_o_reg);
                        rindex_reg    <= cur_i_reg;
                        rorder_reg    <= cur_o_reg;
                        moved_reg     <= (cur_i_reg != idx_reg);
                        state_reg     <= ST_FINISH;
                    end
                end

                // first-fit walk of the pool for order s
                ST_SCAN_RD:
                begin
                    if (p_reg[PW-1])
                    begin
                        if (s_reg == MAX_ORD)
                        begin
                            stat_reg  <= bba_pkg::STAT_NO_SPACE;
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            s_reg <= s_reg + OW'(1);
                            p_reg <= '0;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_SCAN_CHK;
                    end
                end

                ST_SCAN_CHK:
                begin
                    if (scan_hit)
                    begin
                        gi_reg    <= p_reg[IW-1:0];
                        state_reg <= ST_SPLIT;
                    end
                    else
                    begin
                        p_reg <= p_step;
                        if (p_step[PW-1])
                        begin
                            state_reg <= ST_SCAN_RD;
                        end
                    end
                end

                ST_SPLIT:
                begin
                    if (s_reg > dest_reg)
                    begin
                        s_reg          <= s_dn;
                        free_blk_reg   <= free_blk_reg + BW'(1);
                        total_blk_reg  <= total_blk_reg + BW'(1);
                        free_byte_reg  <= free_byte_reg - YW'(bba_pkg::HeaderBytes);
                        total_byte_reg <= total_byte_reg - YW'(bba_pkg::HeaderBytes);
                    end
                    else
                    begin
                        rindex_reg <= gi_reg;
                        rorder_reg <= dest_reg;
                        if (move_reg)
                        begin
                            // release the old block right after the grant
                            moved_reg     <= 1'b1;
                            free_byte_reg <= free_byte_reg - bba_pkg::payload(dest_reg)
                                           + bba_pkg::payload(o0_reg);
                            cur_i_reg     <= idx_reg;
                            cur_o_reg     <= o0_reg;
                            state_reg     <= ST_MERGE_RD;
                        end
                        else
                        begin
                            free_blk_reg  <= free_blk_reg - BW'(1);
                            free_byte_reg <= free_byte_reg - bba_pkg::payload(dest_reg);
                            state_reg     <= ST_FINISH;
                        end
                    end
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg    <= 1'b1;
                        status_reg       <= stat_reg;
                        result_index_reg <= rindex_reg;
                        result_order_reg <= rorder_reg;
                        moved_out_reg    <= moved_reg;
                        free_blocks_reg  <= free_blk_reg;
                        free_bytes_reg   <= free_byte_reg[21:0];
                        total_blocks_reg <= total_blk_reg;
                        total_bytes_reg  <= total_byte_reg[21:0];
                        state_reg        <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign result_index = result_index_reg;
    assign result_order = result_order_reg;
    assign moved        = moved_out_reg;
    assign free_blocks  = free_blocks_reg;
    assign free_bytes   = free_bytes_reg;
    assign total_blocks = total_blocks_reg;
    assign total_bytes  = total_bytes_reg;

    // free part of the pool never exceeds the whole
    a_blk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_blk_reg <= total_blk_reg)
        else $error("free block count above total");

    a_byte_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_byte_reg <= total_byte_reg)
        else $error("free byte count above total");

    // no grant fields on a refused request
    a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != bba_pkg::STAT_OK
        |-> result_index == '0 && result_order == '0 && !moved)
        else $error("grant fields set on refused request");

    // ram never sees a read and write of one entry in one cycle
    a_ram_collide: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && ram_re |-> ram_wa != ram_ra)
        else $error("table read and write collide");

    // one request at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second request taken while busy");

endmodule
